// ===== design/sorted_key_table_core_defines.svh =====
// Assertion macros for the sorted key table design, included by sorted_key_table_core.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef SORTED_KEY_TABLE_CORE_DEFINES_SVH
`define SORTED_KEY_TABLE_CORE_DEFINES_SVH

// Implication checked at every clock edge outside reset.
`define SKT_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Condition that must hold at every clock edge outside reset.
`define SKT_ASSERT_ALWAYS(lbl, cond, msg) \
  `SKT_ASSERT_IMPL(lbl, 1'b1, cond, msg)

`endif

// ===== design/skt_pkg.sv =====
// Shared types and constants for the sorted key table.
// Used by skt_search and sorted_key_table_core; depends on nothing.
package skt_pkg;

  localparam int unsigned KEY_W = 64;

  typedef enum logic [1:0] {
    KIND_LOOKUP = 2'd0,
    KIND_INSERT = 2'd1,
    KIND_REMOVE = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_DONE     = 3'd0,
    ST_DUP      = 3'd1,
    ST_NOTFOUND = 3'd2,
    ST_FULL     = 3'd3,
    ST_ZERO     = 3'd4
  } status_e;

  typedef struct packed {
    logic done;
    logic found;
  } srch_res_t;

endpackage

// ===== design/skt_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; instantiated by sorted_key_table_core.
module skt_ram #(
  parameter int unsigned WIDTH = 96,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/skt_search.sv =====
// Iterative binary search over the sorted entry memory, each probe: S_RD, S_CMP.
// Depends on skt_pkg; reads the memory through a port shared with the top level.
module skt_search #(
  parameter int unsigned TABLE_DEPTH  = 256,
  parameter int unsigned HANDLE_WIDTH = 32
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      start_i,
  input  logic [skt_pkg::KEY_W-1:0]                 key_i,
  input  logic [$clog2(TABLE_DEPTH+1)-1:0]          cnt_i,
  output logic                                      rd_en_o,
  output logic [$clog2(TABLE_DEPTH)-1:0]            rd_addr_o,
  input  logic [skt_pkg::KEY_W+HANDLE_WIDTH-1:0]    rd_data_i,
  output skt_pkg::srch_res_t                        res_o,
  output logic [$clog2(TABLE_DEPTH+1)-1:0]          pos_o,
  output logic [HANDLE_WIDTH-1:0]                   handle_o
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RD,
    S_CMP
  } state_e;

  state_e                    state_q, state_d;
  logic [CW-1:0]             lo_q, lo_d, hi_q, hi_d, mid_q, mid_d, pos_q, pos_d;
  logic [skt_pkg::KEY_W-1:0] key_q, key_d;
  logic [HANDLE_WIDTH-1:0]   hnd_q, hnd_d;
  logic                      done_q, done_d, found_q, found_d;
  logic [CW-1:0]             mid_c;
  logic [skt_pkg::KEY_W-1:0] probe_key;

  assign mid_c     = lo_q + ((hi_q - lo_q) >> 1);
  assign probe_key = rd_data_i[skt_pkg::KEY_W-1:0];

  always_comb begin
    state_d   = state_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    mid_d     = mid_q;
    pos_d     = pos_q;
    key_d     = key_q;
    hnd_d     = hnd_q;
    done_d    = 1'b0;
    found_d   = found_q;
    rd_en_o   = 1'b0;
    rd_addr_o = mid_c[AW-1:0];
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          lo_d    = '0;
          hi_d    = cnt_i;
          key_d   = key_i;
          state_d = S_RD;
        end
      end
      S_RD: begin
        if (lo_q < hi_q) begin
          rd_en_o = 1'b1;
          mid_d   = mid_c;
          state_d = S_CMP;
        end else begin
          done_d  = 1'b1;
          found_d = 1'b0;
          pos_d   = lo_q;
          state_d = S_IDLE;
        end
      end
      S_CMP: begin
        if (key_q == probe_key) begin
          done_d  = 1'b1;
          found_d = 1'b1;
          pos_d   = mid_q;
          hnd_d   = rd_data_i[skt_pkg::KEY_W +: HANDLE_WIDTH];
          state_d = S_IDLE;
        end else if (key_q < probe_key) begin
          hi_d    = mid_q;
          state_d = S_RD;
        end else begin
          lo_d    = mid_q + 1'b1;
          state_d = S_RD;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
      found_q <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q  <= lo_d;
    hi_q  <= hi_d;
    mid_q <= mid_d;
    pos_q <= pos_d;
    key_q <= key_d;
    hnd_q <= hnd_d;
  end

  assign res_o.done  = done_q;
  assign res_o.found = found_q;
  assign pos_o       = pos_q;
  assign handle_o    = hnd_q;

endmodule

// ===== design/sorted_key_table_core.sv =====
// Top level of the sorted key table: request sequencer, entry memory and search unit.
// Depends on skt_pkg, skt_ram, skt_search and sorted_key_table_core_defines.svh.
//
// The table keeps up to TABLE_DEPTH entries in ascending key order in one memory with a
// single read and a single write port. A request runs alone: a binary search, with a read
// state and a compare state per probe, ends a lookup. An insert then moves the entries at
// and above the position up by one slot and a remove moves those above it down, one entry
// per cycle through the memory port, and an insert then writes the new entry. A zero key
// skips the search and goes straight to the response state. The memory needs no clearing
// after reset, since only entries below the entry count are read. The next request is
// taken while the previous result still waits at the output.
`include "sorted_key_table_core_defines.svh"

module sorted_key_table_core #(
  parameter int unsigned TABLE_DEPTH  = 256,
  parameter int unsigned HANDLE_WIDTH = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // key, handle_in
  input  logic [((skt_pkg::KEY_W+HANDLE_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  // kind
  input  logic [1:0] s_axis_tuser,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // handle_out, position, entry_count
  output logic [((HANDLE_WIDTH+2*$clog2(TABLE_DEPTH+1)+7)/8)*8-1:0] m_axis_tdata,
  // found, status
  output logic [3:0] m_axis_tuser
);

  localparam int unsigned AW     = $clog2(TABLE_DEPTH);
  localparam int unsigned CW     = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned EW     = skt_pkg::KEY_W + HANDLE_WIDTH;
  localparam int unsigned OUT_DW = ((HANDLE_WIDTH + 2 * CW + 7) / 8) * 8;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_SHIFT,
    S_INS,
    S_RESP
  } state_e;

  state_e                    state_q, state_d;
  skt_pkg::kind_e            kind_q, kind_d;
  skt_pkg::status_e          status_q, status_d;
  logic [skt_pkg::KEY_W-1:0] key_q, key_d;
  logic [HANDLE_WIDTH-1:0]   hin_q, hin_d, hout_q, hout_d;
  logic [CW-1:0]             cnt_q, cnt_d, pos_q, pos_d, left_q, left_d;
  logic [AW-1:0]             src_q, src_d, dst_q, dst_d;
  logic                      found_q, found_d, up_q, up_d, pend_q, pend_d;
  logic                      m_valid_q, m_valid_d;
  logic [OUT_DW-1:0]         m_data_q, m_data_d;
  logic [3:0]                m_user_q, m_user_d;

  logic                      ram_we, ram_re, sh_re;
  logic [AW-1:0]             ram_waddr, ram_raddr;
  logic [EW-1:0]             ram_wdata, ram_rdata;
  logic                      srch_start, srch_re;
  logic [AW-1:0]             srch_raddr;
  skt_pkg::srch_res_t        srch_res;
  logic [CW-1:0]             srch_pos;
  logic [HANDLE_WIDTH-1:0]   srch_hnd;

  skt_ram #(
    .WIDTH(EW),
    .DEPTH(TABLE_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  skt_search #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .HANDLE_WIDTH(HANDLE_WIDTH)
  ) u_search (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (srch_start),
    .key_i    (key_q),
    .cnt_i    (cnt_q),
    .rd_en_o  (srch_re),
    .rd_addr_o(srch_raddr),
    .rd_data_i(ram_rdata),
    .res_o    (srch_res),
    .pos_o    (srch_pos),
    .handle_o (srch_hnd)
  );

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  assign ram_re    = (state_q == S_SEARCH) ? srch_re : sh_re;
  assign ram_raddr = (state_q == S_SEARCH) ? srch_raddr : src_q;

  always_comb begin
    state_d    = state_q;
    kind_d     = kind_q;
    status_d   = status_q;
    key_d      = key_q;
    hin_d      = hin_q;
    hout_d     = hout_q;
    cnt_d      = cnt_q;
    pos_d      = pos_q;
    left_d     = left_q;
    src_d      = src_q;
    dst_d      = dst_q;
    found_d    = found_q;
    up_d       = up_q;
    pend_d     = pend_q;
    m_valid_d  = m_valid_q;
    m_data_d   = m_data_q;
    m_user_d   = m_user_q;
    srch_start = 1'b0;
    sh_re      = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = dst_q;
    ram_wdata  = ram_rdata;

    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          kind_d  = skt_pkg::kind_e'(s_axis_tuser);
          key_d   = s_axis_tdata[skt_pkg::KEY_W-1:0];
          hin_d   = s_axis_tdata[skt_pkg::KEY_W +: HANDLE_WIDTH];
          found_d = 1'b0;
          hout_d  = '0;
          pos_d   = '0;
          if (s_axis_tdata[skt_pkg::KEY_W-1:0] == '0) begin
            status_d = skt_pkg::ST_ZERO;
            state_d  = S_RESP;
          end else begin
            state_d = S_SEARCH;
          end
        end
      end
      S_SEARCH: begin
        srch_start = !srch_res.done;
        if (srch_res.done) begin
          srch_start = 1'b0;
          found_d    = srch_res.found;
          pos_d      = srch_pos;
          hout_d     = srch_res.found ? srch_hnd : '0;
          pend_d     = 1'b0;
          state_d    = S_RESP;
          case (kind_q)
            skt_pkg::KIND_INSERT: begin
              if (srch_res.found) begin
                status_d = skt_pkg::ST_DUP;
              end else if (cnt_q == CW'(TABLE_DEPTH)) begin
                status_d = skt_pkg::ST_FULL;
              end else begin
                status_d = skt_pkg::ST_DONE;
                up_d     = 1'b1;
                src_d    = AW'(cnt_q - 1'b1);
                left_d   = cnt_q - srch_pos;
                state_d  = S_SHIFT;
              end
            end
            skt_pkg::KIND_REMOVE: begin
              if (srch_res.found) begin
                status_d = skt_pkg::ST_DONE;
                up_d     = 1'b0;
                src_d    = AW'(srch_pos + 1'b1);
                left_d   = cnt_q - srch_pos - 1'b1;
                state_d  = S_SHIFT;
              end else begin
                status_d = skt_pkg::ST_NOTFOUND;
              end
            end
            default: begin
              status_d = srch_res.found ? skt_pkg::ST_DONE : skt_pkg::ST_NOTFOUND;
            end
          endcase
        end
      end
      S_SHIFT: begin
        ram_we = pend_q;
        if (left_q != '0) begin
          sh_re  = 1'b1;
          pend_d = 1'b1;
          dst_d  = up_q ? src_q + 1'b1 : src_q - 1'b1;
          src_d  = up_q ? src_q - 1'b1 : src_q + 1'b1;
          left_d = left_q - 1'b1;
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            if (up_q) begin
              state_d = S_INS;
            end else begin
              cnt_d   = cnt_q - 1'b1;
              state_d = S_RESP;
            end
          end
        end
      end
      S_INS: begin
        ram_we    = 1'b1;
        ram_waddr = pos_q[AW-1:0];
        ram_wdata = {hin_q, key_q};
        cnt_d     = cnt_q + 1'b1;
        state_d   = S_RESP;
      end
      S_RESP: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_data_d  = OUT_DW'({cnt_q, pos_q, hout_q});
          m_user_d  = {status_q, found_q};
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      pend_q    <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      pend_q    <= pend_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q   <= kind_d;
    status_q <= status_d;
    key_q    <= key_d;
    hin_q    <= hin_d;
    hout_q   <= hout_d;
    pos_q    <= pos_d;
    left_q   <= left_d;
    src_q    <= src_d;
    dst_q    <= dst_d;
    found_q  <= found_d;
    up_q     <= up_d;
    m_data_q <= m_data_d;
    m_user_q <= m_user_d;
  end

  `SKT_ASSERT_ALWAYS(a_cnt_bound, cnt_q <= CW'(TABLE_DEPTH), "entry count above table depth")
  `SKT_ASSERT_ALWAYS(a_cnt_step, CW'(cnt_q - $past(cnt_q) + 1'b1) <= CW'(2), "count jumped")
  `SKT_ASSERT_IMPL(a_wr_range, ram_we, CW'(ram_waddr) <= cnt_q, "write beyond the count")
  `SKT_ASSERT_IMPL(a_srch_owner, srch_res.done, state_q == S_SEARCH, "search done out of turn")

endmodule

// ===== tb/tb_sorted_key_table_core.sv =====
// Self-checking bench for sorted_key_table_core: lookup, insert, remove and spare kinds.
// A scoreboard class keeps its own sorted table and predicts every reply word.
// Depends on skt_pkg and the sorted_key_table_core RTL.
`timescale 1ns / 1ps

module tb_sorted_key_table_core;
  import skt_pkg::*;

  localparam int unsigned TABLE_DEPTH = 256;
  localparam int unsigned HANDLE_WIDTH = 32;
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned REQ_W = ((KEY_W + HANDLE_WIDTH + 7) / 8) * 8;
  localparam int unsigned RSP_W = ((HANDLE_WIDTH + 2 * CNT_W + 7) / 8) * 8;
  localparam logic [1:0] KIND_SPARE = 2'd3;
  localparam int unsigned IDLE_LIMIT = 4000;
  localparam int unsigned TAIL_CYCLES = 300;

  typedef struct {
    logic found;
    logic [HANDLE_WIDTH-1:0] handle;
    logic [CNT_W-1:0] position;
    status_e status;
    logic [CNT_W-1:0] count;
  } table_reply_t;

  class sorted_table_tracker;
    logic [KEY_W-1:0] key_mem[TABLE_DEPTH];
    logic [HANDLE_WIDTH-1:0] handle_mem[TABLE_DEPTH];
    int used;
    table_reply_t expected_replies[$];
    int errors;

    function new();
      used = 0;
      errors = 0;
    endfunction

    function void note_request(logic [1:0] kind, logic [KEY_W-1:0] key,
                               logic [HANDLE_WIDTH-1:0] handle);
      table_reply_t r;
      int lo;
      int hi;
      int mid;
      r.found = 1'b0;
      r.handle = '0;
      r.position = '0;
      if (key == '0) begin
        r.status = ST_ZERO;
      end else begin
        lo = 0;
        hi = used - 1;
        mid = lo + (hi - lo + 1) / 2;
        while (lo <= hi && !r.found) begin
          if (key == key_mem[mid]) begin
            r.found = 1'b1;
          end else begin
            if (key < key_mem[mid]) hi = mid - 1;
            else lo = mid + 1;
            mid = lo + (hi - lo + 1) / 2;
          end
        end
        if (mid > used) mid = used;
        r.position = CNT_W'(mid);
        if (r.found) r.handle = handle_mem[mid];
        if (kind == KIND_INSERT) begin
          if (r.found) begin
            r.status = ST_DUP;
          end else if (used >= TABLE_DEPTH) begin
            r.status = ST_FULL;
          end else begin
            for (int i = used; i > mid; i--) begin
              key_mem[i] = key_mem[i-1];
              handle_mem[i] = handle_mem[i-1];
            end
            key_mem[mid] = key;
            handle_mem[mid] = handle;
            used++;
            r.status = ST_DONE;
          end
        end else if (kind == KIND_REMOVE) begin
          if (r.found) begin
            for (int i = mid; i + 1 < used; i++) begin
              key_mem[i] = key_mem[i+1];
              handle_mem[i] = handle_mem[i+1];
            end
            used--;
            r.status = ST_DONE;
          end else begin
            r.status = ST_NOTFOUND;
          end
        end else begin
          r.status = r.found ? ST_DONE : ST_NOTFOUND;
        end
      end
      r.count = CNT_W'(used);
      expected_replies = {expected_replies, r};
    endfunction

    function void compare_field(string name, logic [63:0] exp_val, logic [63:0] act_val);
      if (exp_val !== act_val) begin
        $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, exp_val,
                 act_val);
        errors++;
      end
    endfunction

    function void check_reply(logic found, logic [HANDLE_WIDTH-1:0] handle,
                              logic [CNT_W-1:0] position, logic [2:0] status,
                              logic [CNT_W-1:0] count);
      table_reply_t r;
      if (expected_replies.size() == 0) begin
        $display("%0t ns: reply word with none expected, expected none, actual %0h/%0h",
                 $time, status, position);
        errors++;
      end else begin
        r = expected_replies.pop_front();
        compare_field("found", r.found, found);
        compare_field("handle_out", r.handle, handle);
        compare_field("position", r.position, position);
        compare_field("status", r.status, status);
        compare_field("entry_count", r.count, count);
      end
    endfunction

    function logic [KEY_W-1:0] pick_present_key();
      return (used == 0) ? '0 : key_mem[$urandom_range(0, used - 1)];
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  // key, handle_in
  logic [REQ_W-1:0] s_axis_tdata = '0;
  // kind
  logic [1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  // handle_out, position, entry_count
  logic [RSP_W-1:0] m_axis_tdata;
  // found, status
  logic [3:0] m_axis_tuser;

  sorted_table_tracker tracker;
  logic [KEY_W-1:0] key_pool[$];
  bit tx_burst = 1'b0;
  bit rx_burst = 1'b0;
  int rx_wait = 0;
  int idle_cycles = 0;

  sorted_key_table_core #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .HANDLE_WIDTH(HANDLE_WIDTH)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      tracker.note_request(s_axis_tuser, s_axis_tdata[KEY_W-1:0],
                           s_axis_tdata[KEY_W+HANDLE_WIDTH-1:KEY_W]);
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      tracker.check_reply(m_axis_tuser[0], m_axis_tdata[HANDLE_WIDTH-1:0],
                          m_axis_tdata[HANDLE_WIDTH+CNT_W-1:HANDLE_WIDTH],
                          m_axis_tuser[3:1],
                          m_axis_tdata[HANDLE_WIDTH+2*CNT_W-1:HANDLE_WIDTH+CNT_W]);
    end
  end

  always @(posedge clk_i) begin
    int stall;
    if (m_axis_tvalid && m_axis_tready) begin
      stall = rx_burst ? 0 : $urandom_range(0, 11);
      rx_wait <= stall;
      m_axis_tready <= (stall == 0);
    end else if (rx_wait > 0) begin
      rx_wait <= rx_wait - 1;
      m_axis_tready <= (rx_wait == 1);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles == IDLE_LIMIT) begin
        $display("%0t ns: no word moved for %0d cycles", $time, IDLE_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  function automatic void add_pool_key(input logic [KEY_W-1:0] k);
    key_pool = {key_pool, k};
  endfunction

  task automatic send_request(input logic [1:0] kind, input logic [KEY_W-1:0] key,
                              input logic [HANDLE_WIDTH-1:0] handle);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= REQ_W'({handle, key});
    s_axis_tuser <= kind;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (tracker.expected_replies.size() != 0) @(posedge clk_i);
  endtask

  task automatic shuffle_idling();
    tx_burst <= ($urandom_range(0, 3) == 0);
    rx_burst <= ($urandom_range(0, 3) == 0);
  endtask

  task automatic build_pool(input int entries);
    logic [KEY_W-1:0] k;
    key_pool.delete();
    add_pool_key(64'd1);
    add_pool_key(64'd2);
    add_pool_key('1);
    add_pool_key({1'b1, 63'd0});
    add_pool_key({1'b0, {63{1'b1}}});
    while (key_pool.size() < entries) begin
      k = {$urandom, $urandom};
      add_pool_key(k);
      if ($urandom_range(0, 3) == 0) add_pool_key(k + 64'd1);
    end
  endtask

  task automatic send_mixed(input int count);
    logic [1:0] kind;
    logic [KEY_W-1:0] key;
    int pick;
    for (int n = 0; n < count; n++) begin
      if (n % 100 == 0) shuffle_idling();
      pick = $urandom_range(0, 99);
      if (pick < 25) kind = KIND_LOOKUP;
      else if (pick < 65) kind = KIND_INSERT;
      else if (pick < 95) kind = KIND_REMOVE;
      else kind = KIND_SPARE;
      pick = $urandom_range(0, 99);
      if (pick < 4) key = '0;
      else if (pick < 14) key = {$urandom, $urandom};
      else if (pick < 30 && tracker.used > 0) key = tracker.pick_present_key();
      else key = key_pool[$urandom_range(0, key_pool.size() - 1)];
      send_request(kind, key, $urandom);
    end
  endtask

  initial begin
    tracker = new();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_request(KIND_LOOKUP, 64'd1, 32'h0);
    send_request(KIND_REMOVE, 64'd1, 32'h0);
    send_request(KIND_INSERT, '0, '1);
    send_request(KIND_LOOKUP, '0, 32'h0);
    send_request(KIND_REMOVE, '0, 32'h0);
    send_request(KIND_SPARE, '0, 32'h0);
    send_request(KIND_INSERT, '1, '1);
    send_request(KIND_INSERT, 64'd1, 32'h0);
    send_request(KIND_INSERT, {1'b1, 63'd0}, 32'h5555_aaaa);
    send_request(KIND_INSERT, 64'd1, 32'h1234_5678);
    send_request(KIND_LOOKUP, '1, 32'h0);
    send_request(KIND_SPARE, {1'b1, 63'd0}, 32'h0);
    send_request(KIND_SPARE, 64'd2, 32'h0);
    send_request(KIND_INSERT, 64'd2, 32'haaaa_5555);
    send_request(KIND_INSERT, {1'b0, {63{1'b1}}}, 32'h8000_0001);
    send_request(KIND_LOOKUP, 64'd2, 32'h0);
    send_request(KIND_REMOVE, {1'b1, 63'd0}, 32'h0);
    send_request(KIND_REMOVE, 64'd1, 32'h0);
    send_request(KIND_REMOVE, '1, 32'h0);
    send_request(KIND_REMOVE, 64'd7, 32'h0);
    send_request(KIND_LOOKUP, {1'b0, {63{1'b1}}}, 32'h0);
    send_request(KIND_LOOKUP, 64'd2, 32'h0);

    build_pool(40);
    send_mixed(600);

    wait_drained();

    tx_burst <= 1'b1;
    while (tracker.used < TABLE_DEPTH) begin
      send_request(KIND_INSERT, {$urandom, $urandom}, $urandom);
    end
    wait_drained();
    shuffle_idling();
    send_request(KIND_INSERT, {$urandom, $urandom}, $urandom);
    send_request(KIND_INSERT, 64'd1, $urandom);
    send_request(KIND_INSERT, '1, $urandom);
    send_request(KIND_INSERT, tracker.pick_present_key(), $urandom);
    send_request(KIND_LOOKUP, tracker.pick_present_key(), 32'h0);
    send_request(KIND_SPARE, tracker.pick_present_key(), 32'h0);
    send_request(KIND_LOOKUP, {$urandom, $urandom}, 32'h0);
    send_request(KIND_REMOVE, {$urandom, $urandom}, 32'h0);
    wait_drained();
    while (tracker.used > 8) begin
      if (tracker.used % 64 == 0) shuffle_idling();
      send_request(KIND_REMOVE, tracker.pick_present_key(), 32'h0);
      wait_drained();
    end

    build_pool(200);
    send_mixed(400);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (tracker.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+design
design/skt_pkg.sv
design/skt_ram.sv
design/skt_search.sv
design/sorted_key_table_core.sv
tb/tb_sorted_key_table_core.sv
